### hw/rtl/plri_pkg.sv
// Shared types and constants for the polyline resample interpolator.
package plri_pkg;

	localparam int COORD_BITS = 24;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int ROOT_W     = DIFF_W;
	localparam int STEP_W     = 16;
	localparam int MSD_W      = 24;
	localparam int DVD_W      = STEP_W + COORD_BITS;
	localparam int ACC_W      = 22;
	localparam int PT_W       = COORD_BITS + 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_STEP      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPLIT_DISTANCE = 8'd1;

	localparam logic [STEP_W-1:0] INTERVAL_STEP_RST = 16'd200;
	localparam logic [MSD_W-1:0]  MIN_SPLIT_RST     = 24'd600;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] way_x;
		logic signed [COORD_BITS-1:0] way_y;
		logic signed [COORD_BITS-1:0] way_z;
		logic                         final_waypoint;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic                         end_of_run;
		logic                         path_done;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_SUM, ST_RT3_GO, ST_RT3_WAIT, ST_CHK,
		ST_RT2_GO, ST_RT2_WAIT, ST_CHK2, ST_DN_GO, ST_DN_WAIT, ST_MUL,
		ST_DX_GO, ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT, ST_PINIT, ST_PTS,
		ST_START, ST_FINAL, ST_COMMIT
	} state_t;

	typedef enum logic [1:0] {SRC_START, SRC_POINT, SRC_FINAL} out_src_t;
	typedef enum logic [1:0] {DSEL_NUM, DSEL_X, DSEL_Y} div_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      do_sq;
		logic      do_sum;
		logic      sqrt_start;
		logic      sqrt_3d;
		logic      cap_dis;
		logic      cap_len;
		logic      div_start;
		div_sel_t  div_sel;
		logic      cap_num;
		logic      do_mul;
		logic      cap_qx;
		logic      cap_qy;
		logic      pt_init;
		logic      pt_step;
		logic      out_load;
		out_src_t  out_src;
		logic      out_last;
		logic      commit;
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic fin;
		logic sqrt_done;
		logic div_done;
		logic dis_lt_min;
		logic len_zero;
		logic step_zero;
		logic num_zero;
		logic last_point;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/plri_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module plri_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plri_pkg::SQ_W-1:0]   radicand,
	output logic                        done,
	output logic [plri_pkg::ROOT_W-1:0] root
);
	import plri_pkg::*;

	localparam int CW = $clog2(ROOT_W);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [SQ_W-1:0]   data_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] trial, sub, diff;
	logic              ge;

	assign trial = {rem_q, data_q[SQ_W-1 -: 2]};
	assign sub   = {1'b0, root_q, 2'b01};
	assign ge    = trial >= sub;
	assign diff  = trial - sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			data_q <= data_q << 2;
			rem_q  <= ge ? diff[ROOT_W:0] : trial[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

### hw/rtl/plri_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module plri_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plri_pkg::DVD_W-1:0]  dividend,
	input  logic [plri_pkg::ROOT_W-1:0] divisor,
	output logic                        done,
	output logic [plri_pkg::DVD_W-1:0]  quotient,
	output logic [plri_pkg::ROOT_W-1:0] remainder
);
	import plri_pkg::*;

	localparam int CW = $clog2(DVD_W);

	logic              busy_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [ROOT_W-1:0] rem_q, dsr_q;
	logic [ROOT_W:0]   trial, diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

### hw/rtl/plri_dp.sv
// Datapath: waypoint state, lengths, step fractions, point accumulators, output register.
module plri_dp #(
	parameter int MAX_POINTS_PER_SEGMENT = 63
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  plri_pkg::cmd_t                  cmd,
	output plri_pkg::sts_t                  sts,
	input  plri_pkg::in_item_t              in_data,
	input  logic                            cfg_valid,
	input  logic [plri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plri_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output plri_pkg::out_item_t             out_data
);
	import plri_pkg::*;

	localparam int NW = $clog2(MAX_POINTS_PER_SEGMENT + 1);

	logic [STEP_W-1:0]            step_q;
	logic [MSD_W-1:0]             msd_q;
	in_item_t                     in_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                         have_prev_q;
	logic signed [DIFF_W-1:0]     dx_q, dy_q, dz_q;
	logic [DIFF_W-1:0]            adx, ady, adz;
	logic [SQ_W-1:0]              sqx_q, sqy_q, sqz_q, s2_q, s3_q;
	logic [ROOT_W-1:0]            dis_q, len_q;
	logic [NW-1:0]                num_q, j_q;
	logic [DVD_W-1:0]             prodx_q, prody_q;
	logic [STEP_W+DIFF_W-1:0]     mulx, muly;
	logic [STEP_W-1:0]            qx_q, qy_q;
	logic [ROOT_W-1:0]            rx_q, ry_q, rxa_q, rya_q;
	logic [ACC_W-1:0]             qxa_q, qya_q;
	logic                         out_valid_q;
	out_item_t                    out_q, out_nxt;

	logic                         rt_done, dv_done;
	logic [ROOT_W-1:0]            rt_root, dv_rem, dv_dsr;
	logic [DVD_W-1:0]             dv_quo, dv_dvd;
	logic [ROOT_W:0]              rxs, rys, rxw, ryw;
	logic                         wrap_x, wrap_y;
	logic signed [PT_W-1:0]       offx, offy, sumx, sumy;
	logic signed [COORD_BITS-1:0] px, py;

	localparam logic signed [PT_W-1:0] SAT_HI = PT_W'((1 << (COORD_BITS - 1)) - 1);
	localparam logic signed [PT_W-1:0] SAT_LO = -SAT_HI - PT_W'(1);

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [PT_W-1:0] v);
		if (v > SAT_HI)
			return SAT_HI[COORD_BITS-1:0];
		else if (v < SAT_LO)
			return SAT_LO[COORD_BITS-1:0];
		return v[COORD_BITS-1:0];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= INTERVAL_STEP_RST;
			msd_q  <= MIN_SPLIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INTERVAL_STEP:      step_q <= cfg_data[STEP_W-1:0];
				REG_MIN_SPLIT_DISTANCE: msd_q  <= cfg_data[MSD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				prev_x_q    <= in_q.way_x;
				prev_y_q    <= in_q.way_y;
				prev_z_q    <= in_q.way_z;
				have_prev_q <= !in_q.final_waypoint;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign adx = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
	assign ady = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
	assign adz = dz_q[DIFF_W-1] ? DIFF_W'(-dz_q) : DIFF_W'(dz_q);

	// |d| stays below 2^24, so the product fits the dividend width
	assign mulx = step_q * adx;
	assign muly = step_q * ady;

	assign dv_dvd = (cmd.div_sel == DSEL_NUM) ? DVD_W'(dis_q) :
	                (cmd.div_sel == DSEL_X)   ? prodx_q : prody_q;
	assign dv_dsr = (cmd.div_sel == DSEL_NUM) ? ROOT_W'(step_q) : len_q;

	plri_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (cmd.sqrt_3d ? s3_q : s2_q),
		.done     (rt_done),
		.root     (rt_root)
	);

	plri_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dv_dvd),
		.divisor   (dv_dsr),
		.done      (dv_done),
		.quotient  (dv_quo),
		.remainder (dv_rem)
	);

	// remainder of j*step*|d| over len2d, tracked per point
	assign rxs    = {1'b0, rxa_q} + {1'b0, rx_q};
	assign rys    = {1'b0, rya_q} + {1'b0, ry_q};
	assign wrap_x = rxs >= {1'b0, len_q};
	assign wrap_y = rys >= {1'b0, len_q};
	assign rxw    = rxs - {1'b0, len_q};
	assign ryw    = rys - {1'b0, len_q};

	assign offx = dx_q[DIFF_W-1] ? -$signed(PT_W'(qxa_q)) : $signed(PT_W'(qxa_q));
	assign offy = dy_q[DIFF_W-1] ? -$signed(PT_W'(qya_q)) : $signed(PT_W'(qya_q));
	assign sumx = {{(PT_W-COORD_BITS){prev_x_q[COORD_BITS-1]}}, prev_x_q} + offx;
	assign sumy = {{(PT_W-COORD_BITS){prev_y_q[COORD_BITS-1]}}, prev_y_q} + offy;
	assign px   = sat(sumx);
	assign py   = sat(sumy);

	always_comb begin
		out_nxt = '0;
		case (cmd.out_src)
			SRC_POINT: begin
				out_nxt.out_x = px;
				out_nxt.out_y = py;
				out_nxt.out_z = prev_z_q;
			end
			SRC_FINAL: begin
				out_nxt.out_x     = in_q.way_x;
				out_nxt.out_y     = in_q.way_y;
				out_nxt.out_z     = in_q.way_z;
				out_nxt.path_done = 1'b1;
			end
			default: begin
				out_nxt.out_x = prev_x_q;
				out_nxt.out_y = prev_y_q;
				out_nxt.out_z = prev_z_q;
			end
		endcase
		out_nxt.end_of_run = cmd.out_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
			dx_q <= DIFF_W'(in_data.way_x) - DIFF_W'(prev_x_q);
			dy_q <= DIFF_W'(in_data.way_y) - DIFF_W'(prev_y_q);
			dz_q <= DIFF_W'(in_data.way_z) - DIFF_W'(prev_z_q);
		end
		if (cmd.do_sq) begin
			sqx_q <= adx * adx;
			sqy_q <= ady * ady;
			sqz_q <= adz * adz;
		end
		if (cmd.do_sum) begin
			s2_q <= sqx_q + sqy_q;
			s3_q <= sqx_q + sqy_q + sqz_q;
		end
		if (cmd.cap_dis)
			dis_q <= rt_root;
		if (cmd.cap_len)
			len_q <= rt_root;
		if (cmd.cap_num) begin
			if (step_q == '0 || dv_quo > DVD_W'(MAX_POINTS_PER_SEGMENT))
				num_q <= NW'(MAX_POINTS_PER_SEGMENT);
			else
				num_q <= dv_quo[NW-1:0];
		end
		if (cmd.do_mul) begin
			prodx_q <= mulx[DVD_W-1:0];
			prody_q <= muly[DVD_W-1:0];
		end
		if (cmd.cap_qx) begin
			qx_q <= dv_quo[STEP_W-1:0];
			rx_q <= dv_rem;
		end
		if (cmd.cap_qy) begin
			qy_q <= dv_quo[STEP_W-1:0];
			ry_q <= dv_rem;
		end
		if (cmd.pt_init) begin
			j_q   <= '0;
			qxa_q <= '0;
			qya_q <= '0;
			rxa_q <= '0;
			rya_q <= '0;
		end else if (cmd.pt_step) begin
			j_q   <= j_q + 1'b1;
			qxa_q <= qxa_q + ACC_W'(qx_q) + ACC_W'(wrap_x);
			qya_q <= qya_q + ACC_W'(qy_q) + ACC_W'(wrap_y);
			rxa_q <= wrap_x ? rxw[ROOT_W-1:0] : rxs[ROOT_W-1:0];
			rya_q <= wrap_y ? ryw[ROOT_W-1:0] : rys[ROOT_W-1:0];
		end
		if (cmd.out_load)
			out_q <= out_nxt;
	end

	assign sts.have_prev  = have_prev_q;
	assign sts.fin        = in_q.final_waypoint;
	assign sts.sqrt_done  = rt_done;
	assign sts.div_done   = dv_done;
	assign sts.dis_lt_min = dis_q < ROOT_W'(msd_q);
	assign sts.len_zero   = len_q == '0;
	assign sts.step_zero  = step_q == '0;
	assign sts.num_zero   = num_q == '0;
	assign sts.last_point = j_q == num_q - 1'b1;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

### hw/rtl/plri_ctrl.sv
// Controller: sequences one waypoint through lengths, divisions and point emission.
module plri_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  plri_pkg::sts_t sts,
	output plri_pkg::cmd_t cmd
);
	import plri_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_SQ;
			ST_SQ: begin
				if (sts.have_prev)
					state_nxt = ST_SUM;
				else
					state_nxt = sts.fin ? ST_FINAL : ST_COMMIT;
			end
			ST_SUM:      state_nxt = ST_RT3_GO;
			ST_RT3_GO:   state_nxt = ST_RT3_WAIT;
			ST_RT3_WAIT: if (sts.sqrt_done) state_nxt = ST_CHK;
			ST_CHK:      state_nxt = sts.dis_lt_min ? ST_START : ST_RT2_GO;
			ST_RT2_GO:   state_nxt = ST_RT2_WAIT;
			ST_RT2_WAIT: if (sts.sqrt_done) state_nxt = ST_CHK2;
			ST_CHK2: begin
				if (sts.len_zero)
					state_nxt = ST_START;
				else
					state_nxt = sts.step_zero ? ST_MUL : ST_DN_GO;
			end
			ST_DN_GO:    state_nxt = ST_DN_WAIT;
			ST_DN_WAIT:  if (sts.div_done) state_nxt = ST_MUL;
			ST_MUL:      state_nxt = ST_DX_GO;
			ST_DX_GO:    state_nxt = ST_DX_WAIT;
			ST_DX_WAIT:  if (sts.div_done) state_nxt = ST_DY_GO;
			ST_DY_GO:    state_nxt = ST_DY_WAIT;
			ST_DY_WAIT:  if (sts.div_done) state_nxt = ST_PINIT;
			ST_PINIT: begin
				if (!sts.num_zero)
					state_nxt = ST_PTS;
				else
					state_nxt = sts.fin ? ST_FINAL : ST_COMMIT;
			end
			ST_PTS: begin
				if (sts.out_free && sts.last_point)
					state_nxt = sts.fin ? ST_FINAL : ST_COMMIT;
			end
			ST_START:    if (sts.out_free) state_nxt = sts.fin ? ST_FINAL : ST_COMMIT;
			ST_FINAL:    if (sts.out_free) state_nxt = ST_COMMIT;
			ST_COMMIT:   state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.out_src = SRC_START;
		cmd.div_sel = DSEL_NUM;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_SQ:       cmd.do_sq = 1'b1;
			ST_SUM:      cmd.do_sum = 1'b1;
			ST_RT3_GO: begin
				cmd.sqrt_start = 1'b1;
				cmd.sqrt_3d    = 1'b1;
			end
			ST_RT3_WAIT: cmd.cap_dis = sts.sqrt_done;
			ST_RT2_GO:   cmd.sqrt_start = 1'b1;
			ST_RT2_WAIT: cmd.cap_len = sts.sqrt_done;
			// zero step saturates the count without a division
			ST_CHK2:     cmd.cap_num = !sts.len_zero && sts.step_zero;
			ST_DN_GO:    cmd.div_start = 1'b1;
			ST_DN_WAIT:  cmd.cap_num = sts.div_done;
			ST_MUL:      cmd.do_mul = 1'b1;
			ST_DX_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_X;
			end
			ST_DX_WAIT:  cmd.cap_qx = sts.div_done;
			ST_DY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_Y;
			end
			ST_DY_WAIT:  cmd.cap_qy = sts.div_done;
			ST_PINIT:    cmd.pt_init = 1'b1;
			ST_PTS: begin
				cmd.out_src  = SRC_POINT;
				cmd.out_load = sts.out_free;
				cmd.pt_step  = sts.out_free;
				cmd.out_last = sts.last_point && !sts.fin;
			end
			ST_START: begin
				cmd.out_load = sts.out_free;
				cmd.out_last = !sts.fin;
			end
			ST_FINAL: begin
				cmd.out_src  = SRC_FINAL;
				cmd.out_load = sts.out_free;
				cmd.out_last = 1'b1;
			end
			ST_COMMIT:   cmd.commit = 1'b1;
			default: ;
		endcase
	end
endmodule

### hw/rtl/polyline_resample_interpolator.sv
// One waypoint is processed at a time; a split segment runs through two roots
// (3-D distance, 2-D length) and up to three divisions (count, x and y step)
// before its inserted points are emitted.
// A request is taken only when the previous waypoint is fully processed.
// Reset: async active low; clears previous waypoint, config to 200 / 600.
// Top level: polyline resampler with config port and output register.
module polyline_resample_interpolator #(
	parameter int MAX_POINTS_PER_SEGMENT = 63
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  plri_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output plri_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plri_pkg::CFG_DATA_W-1:0] cfg_data
);
	import plri_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	plri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	plri_dp #(
		.MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in progress");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.path_done |-> out_data.end_of_run)
		else $error("path end not flagged as last result");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || !out_stall)
		else $error("output register overwritten while stalled");
endmodule
